FILE: rtl/core/gpiocl_pkg.sv
package gpiocl_pkg;

    localparam int PIN_COUNT = 16;

    localparam logic [31:0] CFG_RESET   = 32'h4444_4444;
    localparam int          KEY_BIT_POS = 16;

    // pins that exist on this port
    localparam logic [15:0] PIN_MASK =
        (PIN_COUNT >= 16) ? 16'hFFFF : 16'((32'd1 << PIN_COUNT) - 32'd1);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [2:0] SEL_CFG_LOW   = 3'd0;
    localparam logic [2:0] SEL_CFG_HIGH  = 3'd1;
    localparam logic [2:0] SEL_INPUT     = 3'd2;
    localparam logic [2:0] SEL_OUTPUT    = 3'd3;
    localparam logic [2:0] SEL_SET_RESET = 3'd4;
    localparam logic [2:0] SEL_RESET     = 3'd5;
    localparam logic [2:0] SEL_LOCK      = 3'd6;

    typedef struct packed {
        logic        command;
        logic [2:0]  reg_select;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_gpio_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic        lock_active;
    } t_gpio_rsp;

    // nibbles of a config word that belong to absent pins
    function automatic logic [31:0] cfg_absent_keep(input int first);
        logic [31:0] keep;
        keep = '0;
        for (int i = 0; i < 8; i++) begin
            if (first + i >= PIN_COUNT) begin
                keep[4*i +: 4] = 4'hF;
            end
        end
        return keep;
    endfunction

endpackage

FILE: rtl/core/gpiocl_regs.sv
module gpiocl_regs
    import gpiocl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_take,
    input  t_gpio_req i_req,
    output t_gpio_rsp o_rsp
);

    typedef enum logic [1:0] {
        KEY_IDLE,
        KEY_ONE,
        KEY_ZERO,
        KEY_ARMED
    } t_key_step;

    localparam logic [31:0] KeepLow  = cfg_absent_keep(0);
    localparam logic [31:0] KeepHigh = cfg_absent_keep(8);

    logic [31:0] r_cfg_low,  n_cfg_low;
    logic [31:0] r_cfg_high, n_cfg_high;
    logic [15:0] r_latch,    n_latch;
    logic [15:0] r_lock_mask, n_lock_mask;
    logic        r_key_set,  n_key_set;
    t_key_step   r_step,     n_step;

    logic [31:0] keep_low;
    logic [31:0] keep_high;
    logic [15:0] lock_bits;
    logic        lock_key;
    logic        lock_same;
    logic [31:0] rd;

    // locked pins and absent pins keep their config nibble
    always_comb begin
        keep_low  = KeepLow;
        keep_high = KeepHigh;
        for (int i = 0; i < 8; i++) begin
            if (r_key_set && r_lock_mask[i]) begin
                keep_low[4*i +: 4] = 4'hF;
            end
            if (r_key_set && r_lock_mask[8+i]) begin
                keep_high[4*i +: 4] = 4'hF;
            end
        end
    end

    assign lock_bits = i_req.write_data[15:0] & PIN_MASK;
    assign lock_key  = i_req.write_data[KEY_BIT_POS];
    assign lock_same = (lock_bits == r_lock_mask);

    always_comb begin
        n_cfg_low   = r_cfg_low;
        n_cfg_high  = r_cfg_high;
        n_latch     = r_latch;
        n_lock_mask = r_lock_mask;
        n_key_set   = r_key_set;
        n_step      = r_step;
        rd          = '0;
        if (i_req.command == CMD_WRITE) begin
            unique case (i_req.reg_select)
                SEL_CFG_LOW: begin
                    n_cfg_low = (r_cfg_low & keep_low) | (i_req.write_data & ~keep_low);
                end
                SEL_CFG_HIGH: begin
                    n_cfg_high = (r_cfg_high & keep_high) | (i_req.write_data & ~keep_high);
                end
                SEL_OUTPUT: begin
                    n_latch = i_req.write_data[15:0] & PIN_MASK;
                end
                SEL_LOCK: begin
                    if (!r_key_set) begin
                        if (r_step == KEY_ONE && !lock_key && lock_same) begin
                            n_step = KEY_ZERO;
                        end else if (r_step == KEY_ZERO && lock_key && lock_same) begin
                            n_step = KEY_ARMED;
                        end else begin
                            // wrong step restarts the sequence
                            n_step = lock_key ? KEY_ONE : KEY_IDLE;
                        end
                        n_lock_mask = lock_bits;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            unique case (i_req.reg_select)
                SEL_CFG_LOW:  rd = r_cfg_low;
                SEL_CFG_HIGH: rd = r_cfg_high;
                SEL_INPUT:    rd = {16'h0, i_req.pin_levels & PIN_MASK};
                SEL_OUTPUT:   rd = {16'h0, r_latch};
                SEL_LOCK: begin
                    rd = {16'h0, r_lock_mask};
                    if (r_key_set) begin
                        rd[KEY_BIT_POS] = 1'b1;
                    end else begin
                        // read after the third key write commits the lock
                        if (r_step == KEY_ARMED) begin
                            n_key_set = 1'b1;
                        end
                        n_step = KEY_IDLE;
                    end
                end
                default: rd = '0;
            endcase
        end
    end

    assign o_rsp.read_data   = rd;
    assign o_rsp.pin_drive   = n_latch;
    assign o_rsp.lock_active = n_key_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low   <= CFG_RESET;
            r_cfg_high  <= CFG_RESET;
            r_latch     <= '0;
            r_lock_mask <= '0;
            r_key_set   <= 1'b0;
            r_step      <= KEY_IDLE;
        end else if (i_req_take) begin
            r_cfg_low   <= n_cfg_low;
            r_cfg_high  <= n_cfg_high;
            r_latch     <= n_latch;
            r_lock_mask <= n_lock_mask;
            r_key_set   <= n_key_set;
            r_step      <= n_step;
        end
    end

endmodule

FILE: rtl/core/gpio_port_with_config_lock.sv
// channel   signals                          direction
// request   i_req_valid, o_req_stall, i_req  in  (command, select, data, pin levels)
// response  o_rsp_valid, i_rsp_stall, o_rsp  out (read data, pin drive, lock flag)
//
// one request per cycle unless request stall is high; its response is registered
// register state updates at the edge that takes the request
// a two-entry output (result register plus skid) keeps requests flowing while
// the response side stalls; request stall rises only when both entries are full
// reset is synchronous and restores config words to 0x44444444, other state and valids to 0
module gpio_port_with_config_lock
    import gpiocl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_stall,
    input  t_gpio_req i_req,
    output logic      o_rsp_valid,
    input  logic      i_rsp_stall,
    output t_gpio_rsp o_rsp
);

    logic      req_take;
    logic      out_free;
    t_gpio_rsp rsp;

    logic      r_out_valid;
    t_gpio_rsp r_out;
    logic      r_skid_valid;
    t_gpio_rsp r_skid;

    assign o_req_stall = r_skid_valid;
    assign req_take    = i_req_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_rsp_stall;

    gpiocl_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_take (req_take),
        .i_req      (i_req),
        .o_rsp      (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= req_take;
            end
        end else if (req_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (req_take) begin
                r_out <= rsp;
            end
        end else if (req_take) begin
            r_skid <= rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

FILE: tb/sv/tb_gpio_port_with_config_lock.sv
module tb_gpio_port_with_config_lock;
    timeunit 1ns;
    timeprecision 1ps;

    import gpiocl_pkg::*;

    localparam logic [2:0] SEL_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT = 200_000;

    typedef enum logic [1:0] {
        KEY_IDLE,
        KEY_FIRST,
        KEY_ZERO,
        KEY_AGAIN
    } t_key_step;

    class gpio_lock_scoreboard;
        logic [31:0] cfg_low;
        logic [31:0] cfg_high;
        logic [15:0] latch;
        logic [15:0] lock_mask;
        logic        locked;
        t_key_step   step;
        t_gpio_rsp   expected_rsps[$];
        int          errors;
        int          checked;
        int          reads;
        int          writes;

        function new();
            cfg_low   = CFG_RESET;
            cfg_high  = CFG_RESET;
            latch     = '0;
            lock_mask = '0;
            locked    = 1'b0;
            step      = KEY_IDLE;
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

        // absent pins and pins frozen by the lock keep their nibble
        function logic [31:0] merge_cfg(logic [31:0] old, logic [31:0] data, int first);
            logic [31:0] hold;
            int          pin;
            hold = '0;
            for (int i = 0; i < 8; i++) begin
                pin = first + i;
                if (pin >= PIN_COUNT || (locked && lock_mask[pin])) begin
                    hold[4*i +: 4] = 4'hF;
                end
            end
            return (old & hold) | (data & ~hold);
        endfunction

        function void note_request(t_gpio_req r);
            t_gpio_rsp   e;
            logic [15:0] bits;
            logic        key_in;
            logic        same;
            e = '0;
            if (r.command == CMD_WRITE) begin
                writes++;
                case (r.reg_select)
                    SEL_CFG_LOW:  cfg_low  = merge_cfg(cfg_low, r.write_data, 0);
                    SEL_CFG_HIGH: cfg_high = merge_cfg(cfg_high, r.write_data, 8);
                    SEL_OUTPUT:   latch    = r.write_data[15:0] & PIN_MASK;
                    SEL_LOCK: begin
                        if (!locked) begin
                            bits   = r.write_data[15:0] & PIN_MASK;
                            key_in = r.write_data[KEY_BIT_POS];
                            same   = (bits == lock_mask);
                            if (step == KEY_FIRST && !key_in && same) begin
                                step = KEY_ZERO;
                            end else if (step == KEY_ZERO && key_in && same) begin
                                step = KEY_AGAIN;
                            end else begin
                                step = key_in ? KEY_FIRST : KEY_IDLE;
                            end
                            lock_mask = bits;
                        end
                    end
                    default: ;
                endcase
            end else begin
                reads++;
                case (r.reg_select)
                    SEL_CFG_LOW:  e.read_data = cfg_low;
                    SEL_CFG_HIGH: e.read_data = cfg_high;
                    SEL_INPUT:    e.read_data = {16'h0, r.pin_levels & PIN_MASK};
                    SEL_OUTPUT:   e.read_data = {16'h0, latch};
                    SEL_LOCK: begin
                        if (locked) begin
                            e.read_data = {16'h0, lock_mask} | (32'h1 << KEY_BIT_POS);
                        end else begin
                            // the read after the third key write commits the lock
                            e.read_data = {16'h0, lock_mask};
                            if (step == KEY_AGAIN) begin
                                locked = 1'b1;
                            end
                            step = KEY_IDLE;
                        end
                    end
                    default: e.read_data = '0;
                endcase
            end
            e.pin_drive   = latch;
            e.lock_active = locked;
            expected_rsps.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40) begin
                $display("mismatch %s: got %h expected %h", what, got, want);
            end
        endtask

        task check_response(t_gpio_rsp got);
            t_gpio_rsp want;
            if (expected_rsps.size() == 0) begin
                report("response with no request pending", got.read_data, '0);
                return;
            end
            want = expected_rsps.pop_front();
            checked++;
            if (got.read_data !== want.read_data) begin
                report("read_data", got.read_data, want.read_data);
            end
            if (got.pin_drive !== want.pin_drive) begin
                report("pin_drive", 32'(got.pin_drive), 32'(want.pin_drive));
            end
            if (got.lock_active !== want.lock_active) begin
                report("lock_active", 32'(got.lock_active), 32'(want.lock_active));
            end
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_req_valid;
    logic      o_req_stall;
    t_gpio_req i_req;
    logic      o_rsp_valid;
    logic      i_rsp_stall;
    t_gpio_rsp o_rsp;

    gpio_lock_scoreboard sb;
    bit                  idling;
    int                  n_sent;
    int                  cycles;

    gpio_port_with_config_lock u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall) begin
                sb.check_response(o_rsp);
            end
            if (i_req_valid && !o_req_stall) begin
                sb.note_request(i_req);
            end
        end
    end

    // response side stalls in short bursts while idling is set
    initial begin
        i_rsp_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idling && $urandom_range(0, 4) == 0) begin
                i_rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_rsp_stall <= 1'b0;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_gpio_req make_req(logic cmd, logic [2:0] sel, logic [31:0] data,
                                           logic [15:0] pins);
        t_gpio_req r;
        r.command    = cmd;
        r.reg_select = sel;
        r.write_data = data;
        r.pin_levels = pins;
        return r;
    endfunction

    function automatic t_gpio_req random_access(bit allow_lock);
        logic [2:0] sel;
        do begin
            sel = 3'($urandom_range(0, 7));
        end while (!allow_lock && sel == SEL_LOCK);
        return make_req($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, sel, pick_word(),
                        16'(pick_word()));
    endfunction

    // lock write with random don't-care upper bits
    function automatic t_gpio_req lock_write(logic key, logic [15:0] mask);
        return make_req(CMD_WRITE, SEL_LOCK, {15'($urandom), key, mask}, 16'($urandom));
    endfunction

    task automatic send_request(t_gpio_req r);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic wait_for_responses();
        i_req_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() != 0);
    endtask

    // key sequence with random mask; unless complete, one step goes wrong
    task automatic lock_attempt(bit complete);
        logic [15:0] mask;
        int          break_at;
        mask     = 16'($urandom_range(1, 16'hFFFE));
        break_at = complete ? 4 : $urandom_range(0, 3);
        for (int s = 0; s < 4; s++) begin
            // other registers do not disturb the sequence
            if ($urandom_range(0, 2) == 0) begin
                send_request(random_access(1'b0));
            end
            if (s == break_at) begin
                if (s == 3) begin
                    send_request(lock_write(1'($urandom_range(0, 1)), 16'($urandom)));
                end else begin
                    case ($urandom_range(0, 2))
                        0: send_request(lock_write(s == 1, mask));
                        1: send_request(lock_write(s != 1,
                                                   mask ^ (16'h1 << $urandom_range(0, 15))));
                        default: send_request(make_req(CMD_READ, SEL_LOCK, $urandom,
                                                       16'($urandom)));
                    endcase
                end
                break;
            end
            if (s == 3) begin
                send_request(make_req(CMD_READ, SEL_LOCK, $urandom, 16'($urandom)));
            end else begin
                send_request(lock_write(s != 1, mask));
            end
        end
    endtask

    initial begin
        sb          = new();
        idling      = 1'b0;
        n_sent      = 0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, input sampling, output latch, ignored registers
        send_request(make_req(CMD_READ, SEL_CFG_LOW, '1, 16'hFFFF));
        send_request(make_req(CMD_READ, SEL_CFG_HIGH, '0, 16'h0000));
        send_request(make_req(CMD_READ, SEL_INPUT, '0, 16'hFFFF));
        send_request(make_req(CMD_READ, SEL_INPUT, '1, 16'h0000));
        send_request(make_req(CMD_WRITE, SEL_CFG_LOW, '1, 16'h0000));
        send_request(make_req(CMD_WRITE, SEL_CFG_HIGH, '0, 16'hFFFF));
        send_request(make_req(CMD_READ, SEL_CFG_LOW, '0, 16'h0000));
        send_request(make_req(CMD_READ, SEL_CFG_HIGH, '0, 16'h0000));
        send_request(make_req(CMD_WRITE, SEL_OUTPUT, '1, 16'h0000));
        send_request(make_req(CMD_READ, SEL_OUTPUT, '0, 16'h0000));
        send_request(make_req(CMD_WRITE, SEL_INPUT, '1, 16'hFFFF));
        send_request(make_req(CMD_WRITE, SEL_SET_RESET, '1, 16'h0000));
        send_request(make_req(CMD_WRITE, SEL_RESET, '1, 16'h0000));
        send_request(make_req(CMD_WRITE, SEL_UNUSED, '1, 16'h0000));
        send_request(make_req(CMD_READ, SEL_SET_RESET, '1, 16'hFFFF));
        send_request(make_req(CMD_READ, SEL_RESET, '1, 16'hFFFF));
        send_request(make_req(CMD_READ, SEL_UNUSED, '1, 16'hFFFF));
        send_request(make_req(CMD_WRITE, SEL_OUTPUT, 32'hA5A5_5A5A, 16'h0000));
        // aborted key sequences: changed bits, wrong key, early lock read
        send_request(lock_write(1'b1, 16'hFFFF));
        send_request(lock_write(1'b0, 16'h0000));
        send_request(lock_write(1'b1, 16'h00FF));
        send_request(lock_write(1'b0, 16'h00FF));
        send_request(lock_write(1'b0, 16'h00FF));
        send_request(make_req(CMD_READ, SEL_LOCK, '1, 16'h0000));

        // random accesses mixed with broken key sequences
        while (n_sent < 450) begin
            idling = !(n_sent >= 200 && n_sent < 260);
            if ($urandom_range(0, 1) == 0) begin
                lock_attempt(1'b0);
            end else begin
                repeat ($urandom_range(1, 3)) send_request(random_access(1'b1));
            end
        end
        idling = 1'b1;

        // let the port empty out, then commit the lock
        wait_for_responses();
        lock_attempt(1'b1);

        // locked: frozen config nibbles, ignored lock writes
        while (n_sent < 570) begin
            send_request(random_access(1'b1));
        end
        idling = 1'b0;
        while (n_sent < 670) begin
            send_request(random_access(1'b1));
        end

        wait_for_responses();
        repeat (8) @(posedge i_clk);

        $display("%0d requests (%0d reads, %0d writes), %0d responses checked",
                 n_sent, sb.reads, sb.writes, sb.checked);
        $display("key sequences broken at every step, lock committed: %0d", sb.locked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d responses missing", sb.errors, sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
